[sv/infix_to_postfix_converter_top_defines.svh]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_defines
// assertion macros used by the converter top rtl
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define I2P_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2p assertion failed");

// next-cycle implication, disabled in reset
`define I2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2p assertion failed");

`endif

[sv/i2p_pkg.sv]
// ----------------------------------------------------------------------------
// i2p_pkg
// types, character codes and helpers for the infix to postfix converter
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CHAR_W      = 8;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_MOD   = 8'h25;
    localparam logic [CHAR_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

    localparam logic [1:0] KIND_SYMBOL    = 2'd0;
    localparam logic [1:0] KIND_DONE      = 2'd1;
    localparam logic [1:0] KIND_PAREN_ERR = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_symbol;
        logic [1:0]        kind;
        logic              last;
    } res_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_OPER,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        SOP_HOLD,
        SOP_PUSH,
        SOP_POP,
        SOP_REPLACE
    } stack_op_t;

    typedef enum logic [1:0] {
        COP_HOLD,
        COP_ABOVE,
        COP_BELOW
    } cell_op_t;

    typedef struct packed {
        stack_op_t         op;
        logic [CHAR_W-1:0] data;
    } stack_ctrl_t;

    function automatic logic [1:0] prio(input logic [CHAR_W-1:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_POW)
        begin
            p = 2'd3;
        end
        else if (c == CH_MUL || c == CH_DIV || c == CH_MOD)
        begin
            p = 2'd2;
        end
        else if (c == CH_ADD || c == CH_SUB)
        begin
            p = 2'd1;
        end
        return p;
    endfunction

    function automatic logic is_operand(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

[sv/infix_to_postfix_converter_top.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// shunting-yard converter from infix characters to a postfix stream
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall / in_item carry one character or an end
// mark per transaction. result channel: res_valid / res_stall / res_item carry
// postfix characters, done markers and error codes; last marks the final
// result of an input transaction.
// a transaction is taken only while the converter sits idle. operands, '(' and
// operators that pop nothing finish in the cycle they are taken; their result
// is registered onto res_item. an operator that pops moves to the oper state,
// which pops one entry per cycle while the result register can take it; ')'
// moves to the close state, which pops down to and including the first '(' and
// gives the error when no '(' is stacked; the end mark moves to the flush
// state, which pops down to the first '(', gives the error on that '(' and
// then the done marker, only the last after an error.
// results sit in one output register; a stalled result holds it and the
// converter waits, while a new transaction is still taken once the register
// is being drained in the same cycle.
// reset empties the stack and clears the error flag; stack entries themselves
// are not cleared since only entries below the count are read.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_defines.svh"

module infix_to_postfix_converter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  i2p_pkg::in_item_t    in_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output i2p_pkg::res_item_t   res_item
);

    localparam logic [i2p_pkg::CNT_W-1:0] FULL_CNT = i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH);
    localparam logic [i2p_pkg::CNT_W-1:0] ONE_CNT  = i2p_pkg::CNT_W'(1);

    i2p_pkg::state_t             state_reg, state_next;
    logic [i2p_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        err_reg, err_next;
    logic [i2p_pkg::CHAR_W-1:0]  cur_reg, cur_next;
    logic                        res_valid_reg, res_valid_next;
    i2p_pkg::res_item_t          res_item_reg;

    i2p_pkg::stack_ctrl_t        sctl;
    logic [i2p_pkg::CHAR_W-1:0]  top, second;

    logic                        can_emit;
    logic                        emit;
    i2p_pkg::res_item_t          emit_item;
    logic [i2p_pkg::CHAR_W-1:0]  sym;
    logic [1:0]                  p_in, p_cur;
    logic                        full;
    logic                        top_stops_in, top_stops_cur, next_stops_cur;

    i2p_stack u_stack (
        .clk    (clk),
        .ctrl   (sctl),
        .top    (top),
        .second (second)
    );

    assign sym      = in_item.symbol;
    assign can_emit = !res_valid_reg || !res_stall;
    assign full     = (cnt_reg == FULL_CNT);
    assign p_in     = i2p_pkg::prio(sym);
    assign p_cur    = i2p_pkg::prio(cur_reg);

    // popping stops at an empty stack, a '(' or a lower priority operator
    assign top_stops_in   = (cnt_reg == '0) || (top == i2p_pkg::CH_OPEN)
                          || (i2p_pkg::prio(top) < p_in);
    assign top_stops_cur  = (cnt_reg == '0) || (top == i2p_pkg::CH_OPEN)
                          || (i2p_pkg::prio(top) < p_cur);
    assign next_stops_cur = (cnt_reg == ONE_CNT) || (second == i2p_pkg::CH_OPEN)
                          || (i2p_pkg::prio(second) < p_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2p_pkg::ST_IDLE;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            res_item_reg <= emit_item;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        cur_next   = cur_reg;
        emit       = 1'b0;
        emit_item  = '{out_symbol: '0, kind: i2p_pkg::KIND_SYMBOL, last: 1'b0};
        sctl       = '{op: i2p_pkg::SOP_HOLD, data: cur_reg};
        in_stall   = 1'b1;

        unique case (state_reg)
            i2p_pkg::ST_IDLE:
            begin
                in_stall = !can_emit;
                if (in_valid && can_emit)
                begin
                    if (in_item.action)
                    begin
                        // after an error only the done marker goes out
                        if (err_reg)
                        begin
                            cnt_next = '0;
                        end
                        state_next = i2p_pkg::ST_FLUSH;
                    end
                    else if (err_reg)
                    begin
                        state_next = i2p_pkg::ST_IDLE;
                    end
                    else if (i2p_pkg::is_operand(sym))
                    begin
                        emit      = 1'b1;
                        emit_item = '{out_symbol: sym, kind: i2p_pkg::KIND_SYMBOL, last: 1'b1};
                    end
                    else if (sym == i2p_pkg::CH_OPEN || (p_in != 2'd0 && top_stops_in))
                    begin
                        if (full)
                        begin
                            emit      = 1'b1;
                            emit_item = '{out_symbol: '0, kind: i2p_pkg::KIND_OVERFLOW,
                                          last: 1'b1};
                            err_next  = 1'b1;
                        end
                        else
                        begin
                            sctl     = '{op: i2p_pkg::SOP_PUSH, data: sym};
                            cnt_next = cnt_reg + ONE_CNT;
                        end
                    end
                    else if (sym == i2p_pkg::CH_CLOSE)
                    begin
                        state_next = i2p_pkg::ST_CLOSE;
                    end
                    else if (p_in != 2'd0)
                    begin
                        cur_next   = sym;
                        state_next = i2p_pkg::ST_OPER;
                    end
                end
            end

            i2p_pkg::ST_OPER:
            begin
                if (can_emit)
                begin
                    if (top_stops_cur)
                    begin
                        if (full)
                        begin
                            emit      = 1'b1;
                            emit_item = '{out_symbol: '0, kind: i2p_pkg::KIND_OVERFLOW,
                                          last: 1'b1};
                            err_next  = 1'b1;
                        end
                        else
                        begin
                            sctl     = '{op: i2p_pkg::SOP_PUSH, data: cur_reg};
                            cnt_next = cnt_reg + ONE_CNT;
                        end
                        state_next = i2p_pkg::ST_IDLE;
                    end
                    else if (next_stops_cur)
                    begin
                        // last pop: the new operator takes the freed top slot
                        emit       = 1'b1;
                        emit_item  = '{out_symbol: top, kind: i2p_pkg::KIND_SYMBOL, last: 1'b1};
                        sctl       = '{op: i2p_pkg::SOP_REPLACE, data: cur_reg};
                        state_next = i2p_pkg::ST_IDLE;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_item = '{out_symbol: top, kind: i2p_pkg::KIND_SYMBOL, last: 1'b0};
                        sctl.op   = i2p_pkg::SOP_POP;
                        cnt_next  = cnt_reg - ONE_CNT;
                    end
                end
            end

            i2p_pkg::ST_CLOSE:
            begin
                if (can_emit)
                begin
                    if (cnt_reg == '0)
                    begin
                        emit       = 1'b1;
                        emit_item  = '{out_symbol: '0, kind: i2p_pkg::KIND_PAREN_ERR,
                                       last: 1'b1};
                        err_next   = 1'b1;
                        state_next = i2p_pkg::ST_IDLE;
                    end
                    else if (top == i2p_pkg::CH_OPEN)
                    begin
                        sctl.op    = i2p_pkg::SOP_POP;
                        cnt_next   = cnt_reg - ONE_CNT;
                        state_next = i2p_pkg::ST_IDLE;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_item = '{out_symbol: top, kind: i2p_pkg::KIND_SYMBOL,
                                      last: (cnt_reg != ONE_CNT)
                                            && (second == i2p_pkg::CH_OPEN)};
                        sctl.op   = i2p_pkg::SOP_POP;
                        cnt_next  = cnt_reg - ONE_CNT;
                    end
                end
            end

            i2p_pkg::ST_FLUSH:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        emit_item  = '{out_symbol: '0, kind: i2p_pkg::KIND_DONE, last: 1'b1};
                        err_next   = 1'b0;
                        state_next = i2p_pkg::ST_IDLE;
                    end
                    else if (top == i2p_pkg::CH_OPEN)
                    begin
                        // unclosed '(' drops the rest of the stack
                        emit_item = '{out_symbol: '0, kind: i2p_pkg::KIND_PAREN_ERR,
                                      last: 1'b0};
                        cnt_next  = '0;
                    end
                    else
                    begin
                        emit_item = '{out_symbol: top, kind: i2p_pkg::KIND_SYMBOL, last: 1'b0};
                        sctl.op   = i2p_pkg::SOP_POP;
                        cnt_next  = cnt_reg - ONE_CNT;
                    end
                end
            end

            default:
            begin
                state_next = i2p_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `I2P_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= FULL_CNT)
    `I2P_ASSERT_NOW(a_accept_idle, clk, rst_n, in_valid && !in_stall,
                    state_reg == i2p_pkg::ST_IDLE)
    `I2P_ASSERT_NOW(a_overflow_full, clk, rst_n,
                    emit && emit_item.kind == i2p_pkg::KIND_OVERFLOW, full)
    `I2P_ASSERT_NEXT(a_done_clears, clk, rst_n,
                     emit && emit_item.kind == i2p_pkg::KIND_DONE,
                     state_reg == i2p_pkg::ST_IDLE && cnt_reg == '0 && !err_reg)

endmodule

[sv/i2p_cell.sv]
// ----------------------------------------------------------------------------
// i2p_cell
// one entry of the shifting operator stack
// ----------------------------------------------------------------------------
module i2p_cell (
    input  logic                          clk,
    input  i2p_pkg::cell_op_t             op,
    input  logic [i2p_pkg::CHAR_W-1:0]    above,
    input  logic [i2p_pkg::CHAR_W-1:0]    below,
    output logic [i2p_pkg::CHAR_W-1:0]    value
);

    logic [i2p_pkg::CHAR_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            i2p_pkg::COP_ABOVE: data_reg <= above;
            i2p_pkg::COP_BELOW: data_reg <= below;
            default:            data_reg <= data_reg;
        endcase
    end

    assign value = data_reg;

endmodule

[sv/i2p_stack.sv]
// ----------------------------------------------------------------------------
// i2p_stack
// operator stack as a row of cells, top entry in cell zero
// ----------------------------------------------------------------------------
module i2p_stack (
    input  logic                          clk,
    input  i2p_pkg::stack_ctrl_t          ctrl,
    output logic [i2p_pkg::CHAR_W-1:0]    top,
    output logic [i2p_pkg::CHAR_W-1:0]    second
);

    logic [i2p_pkg::CHAR_W-1:0] cell_data [i2p_pkg::STACK_DEPTH];

    for (genvar i = 0; i < i2p_pkg::STACK_DEPTH; i++)
    begin : g_cell
        logic [i2p_pkg::CHAR_W-1:0] above;
        logic [i2p_pkg::CHAR_W-1:0] below;
        i2p_pkg::cell_op_t          op;

        if (i == 0)
        begin : g_first
            assign above = ctrl.data;
        end
        else
        begin : g_inner
            assign above = cell_data[i-1];
        end

        if (i == i2p_pkg::STACK_DEPTH - 1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_upper
            assign below = cell_data[i+1];
        end

        // replace only rewrites the top cell
        always_comb
        begin
            unique case (ctrl.op)
                i2p_pkg::SOP_PUSH:    op = i2p_pkg::COP_ABOVE;
                i2p_pkg::SOP_POP:     op = i2p_pkg::COP_BELOW;
                i2p_pkg::SOP_REPLACE: op = (i == 0) ? i2p_pkg::COP_ABOVE : i2p_pkg::COP_HOLD;
                default:              op = i2p_pkg::COP_HOLD;
            endcase
        end

        i2p_cell u_cell (
            .clk   (clk),
            .op    (op),
            .above (above),
            .below (below),
            .value (cell_data[i])
        );
    end

    assign top    = cell_data[0];
    assign second = cell_data[1];

endmodule

[sim/i2p_postfix_checker.sv]
// ----------------------------------------------------------------------------
// i2p_postfix_checker
// watches both channels of the converter, predicts the postfix stream from
// every accepted input transaction and compares each result transaction
// field by field with the oldest prediction
// ----------------------------------------------------------------------------
module i2p_postfix_checker
    import i2p_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      res_valid,
    input  logic      res_stall,
    input  res_item_t res_item,
    output int        pending,
    output int        fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CHAR_W-1:0] op_stack [STACK_DEPTH];
    int                stack_fill;
    bit                in_error;
    int                mismatches = 0;
    res_item_t         step_results [$];
    res_item_t         postfix_q [$];
    res_item_t         want;

    function automatic int op_rank(input logic [CHAR_W-1:0] c);
        int r;
        r = 0;
        if (c == CH_POW)
        begin
            r = 3;
        end
        else if (c == CH_MUL || c == CH_DIV || c == CH_MOD)
        begin
            r = 2;
        end
        else if (c == CH_ADD || c == CH_SUB)
        begin
            r = 1;
        end
        return r;
    endfunction

    function automatic bit is_alnum(input logic [CHAR_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic emit(input logic [CHAR_W-1:0] c, input logic [1:0] k);
        step_results.push_back('{out_symbol: c, kind: k, last: 1'b0});
    endtask

    task automatic stack_push(input logic [CHAR_W-1:0] c);
        if (stack_fill >= STACK_DEPTH)
        begin
            in_error = 1'b1;
            emit('0, KIND_OVERFLOW);
        end
        else
        begin
            op_stack[stack_fill] = c;
            stack_fill++;
        end
    endtask

    task automatic convert_transaction(input in_item_t it);
        logic [CHAR_W-1:0] top_ch;
        bit                hit_open;
        bit                stop;
        step_results.delete();
        hit_open = 1'b0;
        stop = 1'b0;
        if (it.action)
        begin
            if (!in_error)
            begin
                // flush; a leftover '(' means an open without close
                while (stack_fill > 0 && !hit_open)
                begin
                    stack_fill--;
                    top_ch = op_stack[stack_fill];
                    if (top_ch == CH_OPEN)
                    begin
                        hit_open = 1'b1;
                        emit('0, KIND_PAREN_ERR);
                    end
                    else
                    begin
                        emit(top_ch, KIND_SYMBOL);
                    end
                end
            end
            stack_fill = 0;
            in_error = 1'b0;
            emit('0, KIND_DONE);
        end
        else if (in_error)
        begin
            // discarded until the end mark
        end
        else if (is_alnum(it.symbol))
        begin
            emit(it.symbol, KIND_SYMBOL);
        end
        else if (it.symbol == CH_OPEN)
        begin
            stack_push(it.symbol);
        end
        else if (it.symbol == CH_CLOSE)
        begin
            while (stack_fill > 0 && !hit_open)
            begin
                stack_fill--;
                top_ch = op_stack[stack_fill];
                if (top_ch == CH_OPEN)
                begin
                    hit_open = 1'b1;
                end
                else
                begin
                    emit(top_ch, KIND_SYMBOL);
                end
            end
            if (!hit_open)
            begin
                in_error = 1'b1;
                emit('0, KIND_PAREN_ERR);
            end
        end
        else if (op_rank(it.symbol) != 0)
        begin
            while (stack_fill > 0 && !stop)
            begin
                top_ch = op_stack[stack_fill-1];
                if (top_ch == CH_OPEN || op_rank(top_ch) < op_rank(it.symbol))
                begin
                    stop = 1'b1;
                end
                else
                begin
                    stack_fill--;
                    emit(top_ch, KIND_SYMBOL);
                end
            end
            stack_push(it.symbol);
        end
        if (step_results.size() > 0)
        begin
            step_results[step_results.size()-1].last = 1'b1;
        end
        foreach (step_results[i])
        begin
            postfix_q.push_back(step_results[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_fill = 0;
            in_error = 1'b0;
            postfix_q.delete();
            pending <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            // a result never comes out at the edge its input transaction is taken
            if (res_valid && !res_stall)
            begin
                if (postfix_q.size() == 0)
                begin
                    $error("result with nothing expected: out_symbol %h kind %0d last %0d",
                           res_item.out_symbol, res_item.kind, res_item.last);
                    mismatches++;
                end
                else
                begin
                    want = postfix_q.pop_front();
                    if (res_item.out_symbol !== want.out_symbol)
                    begin
                        $error("out_symbol: expected %h, got %h",
                               want.out_symbol, res_item.out_symbol);
                        mismatches++;
                    end
                    if (res_item.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, res_item.kind);
                        mismatches++;
                    end
                    if (res_item.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, res_item.last);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                convert_transaction(in_item);
            end
            pending <= postfix_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

[sim/tb_infix_to_postfix_converter_top.sv]
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_top
// drives infix expressions into the converter, directed corner cases first
// and then random well-formed, noisy and stack-filling expressions, with
// random idle bursts on both channels; the checker judges every result
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter_top;
    import i2p_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 220;
    localparam int QUIET_TAIL     = 40;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_item;

    int pending;
    int fail_count;
    int items_done   = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int stall_left   = 0;
    int stuck_cycles = 0;
    bit steady       = 1'b0;

    infix_to_postfix_converter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    i2p_postfix_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stall bursts, started at random while not steady
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < stall_pct)
        begin
            res_stall <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (res_valid && !res_stall))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL infix_to_postfix_converter_top");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    function automatic bit is_token(input logic [CHAR_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
            || c == CH_OPEN || c == CH_CLOSE || c == CH_POW || c == CH_MUL
            || c == CH_DIV || c == CH_MOD || c == CH_ADD || c == CH_SUB;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_operand();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 2))
            0:       c = 8'("0" + $urandom_range(0, 9));
            1:       c = 8'("A" + $urandom_range(0, 25));
            default: c = 8'("a" + $urandom_range(0, 25));
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_operator();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 5))
            0:       c = CH_POW;
            1:       c = CH_MUL;
            2:       c = CH_DIV;
            3:       c = CH_MOD;
            4:       c = CH_ADD;
            default: c = CH_SUB;
        endcase
        return c;
    endfunction

    // holds valid high across back-to-back transactions
    task automatic drive_item(input logic act, input logic [CHAR_W-1:0] ch);
        if (!steady && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{action: act, symbol: ch};
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (act || is_token(ch))
        begin
            items_done++;
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        drive_item(1'b0, ch);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic send_end();
        drive_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_wellformed(input int terms);
        int depth;
        depth = 0;
        for (int t = 0; t < terms; t++)
        begin
            while (depth < 6 && $urandom_range(0, 3) == 0)
            begin
                send_char(CH_OPEN);
                depth++;
            end
            send_char(pick_operand());
            while (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                send_char(CH_CLOSE);
                depth--;
            end
            if (t != terms - 1)
            begin
                send_char(pick_operator());
            end
        end
        while (depth > 0)
        begin
            send_char(CH_CLOSE);
            depth--;
        end
        send_end();
    endtask

    task automatic send_noisy(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0, 1:    send_char(8'($urandom_range(0, 255)));
                2:       send_char($urandom_range(0, 1) ? pick_operator()
                                   : ($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE));
                default: send_char(pick_operand());
            endcase
        end
        send_end();
    endtask

    // fills the stack up to and past its depth
    task automatic send_deep();
        int opens;
        opens = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 1);
        repeat (opens) send_char(CH_OPEN);
        send_text("a+b*c^d");
        repeat ($urandom_range(0, 3)) send_char(CH_CLOSE);
        send_end();
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
            0:       stall_pct <= 0;
            1:       stall_pct <= 15;
            default: stall_pct <= 50;
        endcase
    endtask

    initial
    begin
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operator and operand range, open without close at the end
        send_text("A^Z%0/9*a-z+(");
        drive_item(1'b1, 8'hFF);
        // close without open, then characters discarded until the end mark
        send_char(8'h00);
        send_char(CH_CLOSE);
        send_char("b");
        drive_item(1'b1, 8'h00);
        // ignored character inside a matched pair
        send_char(CH_OPEN);
        send_char(8'hFF);
        send_text("a+b)");
        drive_item(1'b1, 8'hFF);

        pick_idling();
        send_deep();
        while (items_done < ITEM_TARGET)
        begin
            if (items_done > ITEM_TARGET - QUIET_TAIL)
            begin
                steady <= 1'b1;
                gap_pct = 0;
            end
            else
            begin
                pick_idling();
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_deep();
            end
            else if (pick < 70)
            begin
                send_wellformed($urandom_range(1, 8));
            end
            else
            begin
                send_noisy($urandom_range(1, 12));
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS infix_to_postfix_converter_top");
        end
        else
        begin
            $display("FAIL infix_to_postfix_converter_top");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/i2p_pkg.sv
sv/i2p_cell.sv
sv/i2p_stack.sv
sv/infix_to_postfix_converter_top.sv
sim/i2p_postfix_checker.sv
sim/tb_infix_to_postfix_converter_top.sv
